// File: src/sample_without_replacement_top_macros.svh
// Assertion macros for the sampler block.
// No dependencies; included by the modules that check their own logic.
`ifndef SAMPLE_WITHOUT_REPLACEMENT_TOP_MACROS_SVH
`define SAMPLE_WITHOUT_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication
`define SWR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/swr_pkg.sv
// Shared types and constants of the sampler block.
// No dependencies.
package swr_pkg;

	localparam int WORD_W    = 31;
	localparam int VAL_W     = 32;
	localparam int RS_W      = 9;
	localparam int CFG_IDX_W = 2;
	localparam int BIT_CNT_W = 5;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN   = 2'd0,
		REG_RANGE = 2'd1,
		REG_COUNT = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_MOD,
		ST_RD_LAST,
		ST_WRITE
	} state_t;

	typedef struct packed {
		logic              load;
		logic [WORD_W-1:0] dividend;
		logic [RS_W-1:0]   divisor;
	} mod_req_t;

	typedef struct packed {
		logic            done;
		logic [RS_W-1:0] rem;
	} mod_rsp_t;

endpackage

// File: src/swr_mod.sv
// Bit-serial remainder unit: one dividend bit per cycle, restoring form.
// Depends on swr_pkg and the assertion macro header.
`include "sample_without_replacement_top_macros.svh"

module swr_mod (
	input  logic             clk,
	input  logic             arst_n,
	input  swr_pkg::mod_req_t req,
	output swr_pkg::mod_rsp_t rsp
);
	import swr_pkg::*;

	logic [WORD_W-1:0]    word_q;
	logic [RS_W-1:0]      rem_q;
	logic [BIT_CNT_W-1:0] cnt_q;
	logic                 act_q;
	logic                 done_q;
	logic [RS_W:0]        trial;
	logic [RS_W:0]        diff;
	logic [RS_W-1:0]      rem_nxt;

	assign trial   = {rem_q, word_q[WORD_W-1]};
	assign diff    = trial - {1'b0, req.divisor};
	assign rem_nxt = (trial >= {1'b0, req.divisor}) ? diff[RS_W-1:0] : trial[RS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.load) begin
				act_q <= 1'b1;
				cnt_q <= BIT_CNT_W'(WORD_W - 1);
			end else if (act_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					act_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.load) begin
			word_q <= req.dividend;
			rem_q  <= '0;
		end else if (act_q) begin
			word_q <= word_q << 1;
			rem_q  <= rem_nxt;
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q;

	`SWR_ASSERT_NOW(a_rem_below_div, clk, arst_n, done_q, rem_q < req.divisor, "remainder not below divisor")
	`SWR_ASSERT_NEXT(a_done_one_pulse, clk, arst_n, done_q, !done_q, "remainder done held")

endmodule

// File: src/swr_pool.sv
// Pool offset memory: one write port, one read port with registered data.
// No dependencies.
module swr_pool #(
	parameter  int POOL_DEPTH = 256,
	localparam int AW         = $clog2(POOL_DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [AW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [POOL_DEPTH];
	logic [AW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: src/sample_without_replacement_top.sv
// Sampler without replacement (partial shuffle); top level with sequencer and registers.
// One item in flight; the next item is taken at the edge that ends the result strobe,
// unless the set ended and a refill sweep runs first. Invalid settings give an error item
// in the cycle after the start. Set end, a write to one of the three registers and reset
// start a refill sweep (one pool entry per cycle) with busy high. Results cannot be
// stalled. Depends on swr_pkg, swr_mod, swr_pool and the assertion macro header.
`include "sample_without_replacement_top_macros.svh"

module sample_without_replacement_top #(
	parameter int POOL_DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  logic [swr_pkg::WORD_W-1:0]             random_word,
	input  logic                                   cfg_we,
	input  logic [swr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [swr_pkg::VAL_W-1:0]              cfg_data,
	output logic                                   done,
	output logic signed [swr_pkg::VAL_W-1:0]       drawn_value,
	output logic                                   set_last,
	output logic                                   status
);
	import swr_pkg::*;

	localparam int AW = $clog2(POOL_DEPTH);

	state_t                  state_q, state_d;
	logic signed [VAL_W-1:0] min_q;
	logic [RS_W-1:0]         range_q;
	logic [RS_W-1:0]         count_q;
	logic [RS_W-1:0]         remaining_q;
	logic [RS_W-1:0]         drawn_q;
	logic [RS_W-1:0]         idx_q;
	logic [RS_W-1:0]         choice_q;
	logic [AW-1:0]           picked_q;
	logic                    done_q;
	logic signed [VAL_W-1:0] value_q;
	logic                    last_q;
	logic                    status_q;

	logic                    cfg_hit;
	logic                    range_ok;
	logic                    cfg_ok;
	logic signed [VAL_W:0]   top_val;
	logic                    last_draw;

	mod_req_t                mod_req;
	mod_rsp_t                mod_rsp;
	logic                    pool_we;
	logic [AW-1:0]           pool_waddr;
	logic [AW-1:0]           pool_wdata;
	logic [AW-1:0]           pool_raddr;
	logic [AW-1:0]           pool_rdata;

	assign cfg_hit  = cfg_we && (cfg_index inside {REG_MIN, REG_RANGE, REG_COUNT});
	assign range_ok = (range_q != '0) && (32'(range_q) <= 32'(POOL_DEPTH));
	assign top_val  = {min_q[VAL_W-1], min_q} + $signed({{(VAL_W+1-RS_W){1'b0}}, range_q})
		- $signed((VAL_W+1)'(1));
	assign cfg_ok   = range_ok && (count_q != '0) && (count_q <= range_q)
		&& (top_val <= $signed({1'b0, {(VAL_W-1){1'b1}}}));
	assign last_draw = RS_W'(drawn_q + 1'b1) >= count_q;

	swr_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

	swr_pool #(.POOL_DEPTH(POOL_DEPTH)) u_pool (
		.clk   (clk),
		.we    (pool_we),
		.waddr (pool_waddr),
		.wdata (pool_wdata),
		.raddr (pool_raddr),
		.rdata (pool_rdata)
	);

	always_comb begin
		state_d          = state_q;
		busy             = 1'b1;
		mod_req.load     = 1'b0;
		mod_req.dividend = random_word;
		mod_req.divisor  = remaining_q;
		pool_we          = 1'b0;
		pool_waddr       = AW'(idx_q);
		pool_wdata       = AW'(idx_q);
		pool_raddr       = AW'(choice_q);
		case (state_q)
			ST_SWEEP: begin
				pool_we = range_ok;
				if (!range_ok || (RS_W'(idx_q + 1'b1) == range_q)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start && cfg_ok) begin
					mod_req.load = 1'b1;
					state_d      = ST_MOD;
				end
			end
			ST_MOD: begin
				pool_raddr = AW'(mod_rsp.rem);
				if (mod_rsp.done) begin
					state_d = ST_RD_LAST;
				end
			end
			ST_RD_LAST: begin
				pool_raddr = AW'(RS_W'(remaining_q - 1'b1));
				state_d    = ST_WRITE;
			end
			ST_WRITE: begin
				pool_we    = 1'b1;
				pool_waddr = AW'(choice_q);
				pool_wdata = pool_rdata;
				state_d    = last_draw ? ST_SWEEP : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cfg_hit) begin
			state_d = ST_SWEEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q   <= '0;
			range_q <= RS_W'(256);
			count_q <= RS_W'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MIN:   min_q   <= cfg_data;
				REG_RANGE: range_q <= cfg_data[RS_W-1:0];
				REG_COUNT: count_q <= cfg_data[RS_W-1:0];
				default:   ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			idx_q       <= '0;
			remaining_q <= '0;
			drawn_q     <= '0;
			done_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			if (cfg_hit) begin
				idx_q <= '0;
			end else begin
				case (state_q)
					ST_SWEEP: begin
						idx_q <= idx_q + 1'b1;
						if (state_d == ST_IDLE) begin
							remaining_q <= range_q;
							drawn_q     <= '0;
						end
					end
					ST_IDLE: begin
						if (start && !cfg_ok) begin
							done_q <= 1'b1;
						end
					end
					ST_WRITE: begin
						remaining_q <= remaining_q - 1'b1;
						drawn_q     <= drawn_q + 1'b1;
						idx_q       <= '0;
						done_q      <= 1'b1;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_MOD && mod_rsp.done) begin
			choice_q <= mod_rsp.rem;
		end
		if (state_q == ST_RD_LAST) begin
			picked_q <= pool_rdata;
		end
		case (state_q)
			ST_IDLE: begin
				value_q  <= '0;
				last_q   <= 1'b0;
				status_q <= 1'b1;
			end
			ST_WRITE: begin
				value_q  <= min_q + $signed(VAL_W'(picked_q));
				last_q   <= last_draw;
				status_q <= 1'b0;
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign drawn_value = value_q;
	assign set_last    = last_q;
	assign status      = status_q;

	`SWR_ASSERT_NEXT(a_draw_result, clk, arst_n, state_q == ST_WRITE && !cfg_hit, done && !status, "draw gave no result")
	`SWR_ASSERT_NOW(a_pool_live, clk, arst_n, state_q == ST_IDLE && cfg_ok, remaining_q != '0 && remaining_q <= range_q, "live count out of range")
	`SWR_ASSERT_NOW(a_last_refills, clk, arst_n, done && set_last, state_q == ST_SWEEP, "set end without refill")

endmodule

// File: tb/sample_without_replacement_top_test.sv
// Self-checking testbench of sample_without_replacement_top: directed and random draws
// under changing range settings, checked against an in-bench pool shuffle predictor.
// Depends on swr_pkg and the sampler RTL.
`timescale 1ns / 1ps

module sample_without_replacement_top_test;
	import swr_pkg::*;

	localparam int POOL = 256;
	localparam int ITEM_TARGET = 1850;
	localparam int STALL_LIMIT = 5000;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

	typedef struct {
		logic [VAL_W-1:0] value;
		logic             last;
		logic             status;
	} draw_t;

	class draw_scoreboard;
		logic [VAL_W-1:0] min_val;
		logic [RS_W-1:0]  range_sz;
		logic [RS_W-1:0]  count_sz;
		logic [7:0]       pool [POOL];
		int               remaining;
		int               drawn;
		draw_t            draws_q [$];
		int               errors;

		function new();
			min_val = '0;
			range_sz = 9'd256;
			count_sz = 9'd256;
			errors = 0;
			refill();
		endfunction

		function void refill();
			for (int i = 0; i < POOL; i++)
				pool[i] = 8'(i);
			remaining = range_sz;
			drawn = 0;
		endfunction

		function bit setting_ok();
			longint lo;
			lo = longint'($signed(min_val));
			if (range_sz == 0 || range_sz > POOL)
				return 0;
			if (count_sz == 0 || count_sz > range_sz)
				return 0;
			return (lo + longint'(range_sz) - 1 <= 64'sd2147483647);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
			case (idx)
				REG_MIN:   min_val = d;
				REG_RANGE: range_sz = d[RS_W-1:0];
				REG_COUNT: count_sz = d[RS_W-1:0];
				default:   return;
			endcase
			refill();
		endfunction

		function void note_word(logic [WORD_W-1:0] w);
			draw_t       exp_d;
			int unsigned choice;
			logic [7:0]  picked;
			exp_d = '{value: '0, last: 1'b0, status: 1'b1};
			if (setting_ok() && remaining != 0 && remaining <= POOL) begin
				choice = {1'b0, w} % remaining;
				picked = pool[choice];
				pool[choice] = pool[remaining - 1];
				remaining--;
				drawn++;
				exp_d.value = min_val + {24'd0, picked};
				exp_d.status = 1'b0;
				if (drawn >= count_sz) begin
					exp_d.last = 1'b1;
					refill();
				end
			end
			draws_q.push_back(exp_d);
		endfunction

		function void check_draw(logic [VAL_W-1:0] v, logic l, logic s);
			draw_t exp_d;
			if (draws_q.size() == 0) begin
				$error("unexpected item: drawn_value %0d", $signed(v));
				errors++;
				return;
			end
			exp_d = draws_q.pop_front();
			if (v !== exp_d.value) begin
				$error("drawn_value: expected %0d, got %0d", $signed(exp_d.value), $signed(v));
				errors++;
			end
			if (l !== exp_d.last) begin
				$error("set_last: expected %0b, got %0b", exp_d.last, l);
				errors++;
			end
			if (s !== exp_d.status) begin
				$error("status: expected %0b, got %0b", exp_d.status, s);
				errors++;
			end
		endfunction

		function int outstanding();
			return draws_q.size();
		endfunction
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     start;
	logic                     busy;
	logic [WORD_W-1:0]        random_word;
	logic                     cfg_we;
	logic [CFG_IDX_W-1:0]     cfg_index;
	logic [VAL_W-1:0]         cfg_data;
	logic                     done;
	logic signed [VAL_W-1:0]  drawn_value;
	logic                     set_last;
	logic                     status;

	draw_scoreboard board = new();
	int             idle_cycles = 0;
	int             total_items = 0;

	sample_without_replacement_top #(.POOL_DEPTH(POOL)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.random_word(random_word),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.done(done),
		.drawn_value(drawn_value),
		.set_last(set_last),
		.status(status)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				board.check_draw(drawn_value, set_last, status);
			if (start && !busy)
				board.note_word(random_word);
			if (cfg_we)
				board.write_reg(cfg_index, cfg_data);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic send_word(logic [WORD_W-1:0] w);
		start <= 1'b1;
		random_word <= w;
		do
			@(posedge clk);
		while (busy);
	endtask

	task automatic write_port(logic [CFG_IDX_W-1:0] idx, logic [VAL_W-1:0] d);
		start <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0 || busy)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [VAL_W-1:0] pad_size(int v);
		logic [VAL_W-RS_W-1:0] upper;
		upper = ($urandom_range(0, 3) == 0) ? (VAL_W-RS_W)'($urandom) : '0;
		return {upper, RS_W'(v)};
	endfunction

	function automatic logic [WORD_W-1:0] pick_word();
		if ($urandom_range(0, 4) == 0)
			return WORD_W'($urandom_range(0, 600));
		return WORD_W'($urandom);
	endfunction

	task automatic random_phase();
		int               rng;
		int               cnt;
		int               n;
		int               i;
		int               len;
		int               gap;
		int               disrupt_at;
		bit               bad;
		logic [VAL_W-1:0] mv;
		case ($urandom_range(0, 9))
			0, 1:    rng = $urandom_range(17, 255);
			2:       rng = POOL;
			default: rng = $urandom_range(1, 16);
		endcase
		cnt = ($urandom_range(0, 3) == 0) ? rng : $urandom_range(1, rng);
		case ($urandom_range(0, 4))
			0:       mv = 32'h8000_0000;
			1:       mv = 32'h7FFF_FFFF - rng + 1;
			2:       mv = $urandom_range(0, 1000);
			default: mv = $urandom;
		endcase
		if (longint'($signed(mv)) + longint'(rng) - 1 > 64'sd2147483647)
			mv = 32'h7FFF_FFFF - rng + 1;
		bad = ($urandom_range(0, 9) == 0);
		if (bad) begin
			case ($urandom_range(0, 4))
				0: rng = 0;
				1: rng = $urandom_range(POOL + 1, 511);
				2: cnt = 0;
				3: cnt = rng + $urandom_range(1, 511 - rng);
				default: begin
					if (rng == 1)
						rng = 2;
					mv = 32'h7FFF_FFFF - rng + 2;
				end
			endcase
		end
		write_port(REG_MIN, mv);
		write_port(REG_RANGE, pad_size(rng));
		write_port(REG_COUNT, pad_size(cnt));
		if ($urandom_range(0, 7) == 0)
			write_port(REG_NONE, $urandom);
		n = bad ? $urandom_range(1, 4) : cnt * $urandom_range(1, 3);
		if (n > 300)
			n = 300;
		disrupt_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, n) : -1;
		i = 0;
		while (i < n) begin
			len = $urandom_range(1, 12);
			for (int j = 0; j < len && i < n; j++) begin
				send_word(pick_word());
				i++;
				if (i == disrupt_at) begin
					if ($urandom_range(0, 1) == 0)
						write_port(REG_NONE, $urandom);
					else
						write_port(REG_COUNT, pad_size(cnt));
				end
			end
			gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		total_items += n;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		random_word = '0;
		cfg_we = 1'b0;
		cfg_index = REG_MIN;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset setting: full range, whole-pool set
		send_word(31'h0000_0000);
		send_word(31'h7FFF_FFFF);
		send_word(31'h2AAA_AAAA);
		send_word(31'h5555_5555);
		send_word(31'd255);

		// single-value range at the bottom, upper data bits ignored
		write_port(REG_MIN, 32'h8000_0000);
		write_port(REG_RANGE, 32'hFFFF_FE01);
		write_port(REG_COUNT, 32'd1);
		send_word(pick_word());
		send_word(pick_word());

		// top of the signed range, then overflow
		write_port(REG_MIN, 32'h7FFF_FFFF);
		send_word(pick_word());
		write_port(REG_RANGE, 32'd2);
		send_word(pick_word());
		write_port(REG_MIN, 32'h7FFF_FFFE);
		write_port(REG_COUNT, 32'd2);
		send_word(pick_word());
		send_word(pick_word());

		// invalid counts and sizes
		write_port(REG_MIN, 32'hFFFF_FFFB);
		write_port(REG_RANGE, 32'd256);
		write_port(REG_COUNT, 32'd0);
		send_word(pick_word());
		write_port(REG_COUNT, 32'h0000_0101);
		send_word(pick_word());
		write_port(REG_RANGE, 32'd0);
		send_word(pick_word());
		write_port(REG_RANGE, 32'h0000_01FF);
		send_word(pick_word());

		// write to an unused index must not restart the set
		write_port(REG_RANGE, 32'd4);
		write_port(REG_COUNT, 32'd4);
		send_word(pick_word());
		send_word(pick_word());
		write_port(REG_NONE, 32'hFFFF_FFFF);
		send_word(pick_word());
		send_word(pick_word());

		while (total_items < ITEM_TARGET)
			random_phase();

		start <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
